### src/multi_key_record_sorter_core_assert.svh
// assertion macros shared by the sorter rtl
`ifndef MULTI_KEY_RECORD_SORTER_CORE_ASSERT_SVH
`define MULTI_KEY_RECORD_SORTER_CORE_ASSERT_SVH

// condition must hold at every edge outside reset
`define MKRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MKRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MKRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### src/mkrs_pkg.sv
// types, constants and the record ordering function of the record sorter
package mkrs_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int COUNT_W     = $clog2(MAX_RECORDS + 1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] ST_LOADED   = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RETURNED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [63:0] head;
    logic [15:0] tail;
    logic [6:0]  kor;
    logic [6:0]  eng;
    logic [6:0]  mth;
  } record_t;

  typedef struct packed {
    logic load;
    logic read;
  } cell_ctl_t;

  // true when record a sorts strictly ahead of record b
  function automatic logic goes_before(input record_t a, input record_t b);
    logic res;
    if (a.kor != b.kor) begin
      res = a.kor > b.kor;
    end else if (a.eng != b.eng) begin
      res = a.eng < b.eng;
    end else if (a.mth != b.mth) begin
      res = a.mth > b.mth;
    end else if (a.head != b.head) begin
      res = a.head < b.head;
    end else begin
      res = a.tail < b.tail;
    end
    return res;
  endfunction

endpackage

### src/mkrs_cell.sv
// one slot of the sorted insertion chain
module mkrs_cell (
  input  logic              clk,
  input  mkrs_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  mkrs_pkg::record_t new_rec,
  input  mkrs_pkg::record_t prev_rec,
  input  logic              prev_ins,
  input  mkrs_pkg::record_t next_rec,
  output mkrs_pkg::record_t rec,
  output logic              ins
);

  // at or past the insertion point: new record sorts ahead, or slot is free
  assign ins = !occupied || mkrs_pkg::goes_before(new_rec, rec);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ins && !prev_ins) begin
        rec <= new_rec;
      end else if (ins) begin
        rec <= prev_rec;
      end
    end else if (ctl.read) begin
      rec <= next_rec;
    end
  end

endmodule

### src/multi_key_record_sorter_core.sv
// top level of the multi-key record sorter
//
// A sorted store of up to 1024 student records (ten-character name, three
// scores), ordered korean descending, english ascending, math descending,
// then name ascending; records with equal keys keep their arrival order.
// Drive start with mode 0 to load a record or mode 1 to pop the first one.
// Busy stays low, so a new transaction may be issued on every
// clock. Its result appears on the following cycle with
// done high for exactly that one cycle; the receiver cannot stall, so done
// must be sampled when it shows. The store is a row of 1024 cells: on a load
// every cell compares the new record with its own in parallel and the cells
// at and behind the insertion point shift one place back; on a read every
// cell takes its rear neighbor's record. The compare in each cell and the
// fan-out of the new record to the row set the clock period. No clearing
// pass is needed after reset.
module multi_key_record_sorter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [63:0] name_head,
  input  logic [15:0] name_tail,
  input  logic [6:0]  korean_score,
  input  logic [6:0]  english_score,
  input  logic [6:0]  math_score,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] out_name_head,
  output logic [15:0] out_name_tail,
  output logic        is_last
);

  logic [mkrs_pkg::COUNT_W-1:0] count;
  logic                         accept;
  logic                         full;
  logic                         empty;
  mkrs_pkg::cell_ctl_t          ctl;
  mkrs_pkg::record_t            new_rec;
  mkrs_pkg::record_t            rec_chain [mkrs_pkg::MAX_RECORDS];
  logic                         ins_chain [mkrs_pkg::MAX_RECORDS];

  // the chain absorbs a transaction every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count == mkrs_pkg::COUNT_W'(mkrs_pkg::MAX_RECORDS);
  assign empty  = count == '0;

  assign new_rec.head = name_head;
  assign new_rec.tail = name_tail;
  assign new_rec.kor  = korean_score;
  assign new_rec.eng  = english_score;
  assign new_rec.mth  = math_score;

  // a load into a full store and a read of an empty one leave the row alone
  assign ctl.load = accept && (mode == mkrs_pkg::MODE_LOAD) && !full;
  assign ctl.read = accept && (mode == mkrs_pkg::MODE_READ) && !empty;

  // row of cells; cell 0 holds the first record in sort order
  for (genvar i = 0; i < mkrs_pkg::MAX_RECORDS; i++) begin : g_cell
    mkrs_pkg::record_t prev_rec;
    mkrs_pkg::record_t next_rec;
    logic              prev_ins;

    if (i == 0) begin : g_head
      assign prev_rec = new_rec;
      assign prev_ins = 1'b0;
    end else begin : g_body
      assign prev_rec = rec_chain[i-1];
      assign prev_ins = ins_chain[i-1];
    end

    if (i == mkrs_pkg::MAX_RECORDS - 1) begin : g_tail
      assign next_rec = rec_chain[i];
    end else begin : g_mid
      assign next_rec = rec_chain[i+1];
    end

    mkrs_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (count > mkrs_pkg::COUNT_W'(i)),
      .new_rec  (new_rec),
      .prev_rec (prev_rec),
      .prev_ins (prev_ins),
      .next_rec (next_rec),
      .rec      (rec_chain[i]),
      .ins      (ins_chain[i])
    );
  end

  // record count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.load) begin
      count <= count + 1'b1;
    end else if (ctl.read) begin
      count <= count - 1'b1;
    end
  end

  // result register, updated in the cycle after the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (mode == mkrs_pkg::MODE_LOAD) begin
        status        <= full ? mkrs_pkg::ST_FULL : mkrs_pkg::ST_LOADED;
        out_name_head <= '0;
        out_name_tail <= '0;
        is_last       <= 1'b0;
      end else if (empty) begin
        status        <= mkrs_pkg::ST_EMPTY;
        out_name_head <= '0;
        out_name_tail <= '0;
        is_last       <= 1'b0;
      end else begin
        // pop the front cell
        status        <= mkrs_pkg::ST_RETURNED;
        out_name_head <= rec_chain[0].head;
        out_name_tail <= rec_chain[0].tail;
        is_last       <= count == mkrs_pkg::COUNT_W'(1);
      end
    end
  end

`include "multi_key_record_sorter_core_assert.svh"

  `MKRS_ASSERT_ALWAYS(a_count_bound, count <= mkrs_pkg::COUNT_W'(mkrs_pkg::MAX_RECORDS), "count past capacity")
  `MKRS_ASSERT_NEXT(a_done_follows, accept, done, "accepted transaction gave no result")
  `MKRS_ASSERT_NEXT(a_no_spurious, !accept, !done, "result without a transaction")
  `MKRS_ASSERT_NEXT(a_load_counts, ctl.load, count == $past(count) + 1'b1, "load did not grow the store")
  `MKRS_ASSERT_SAME(a_last_empties, done && status == mkrs_pkg::ST_RETURNED && is_last, count == '0, "last record left entries behind")

endmodule
